FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// property shapes used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CQR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cqr_pkg.sv
// ----------------------------------------------------------------------------
// cqr_pkg
// types and codes shared by the circular queue modules
// ----------------------------------------------------------------------------
package cqr_pkg;

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_REV = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // apb byte address of the capacity register
    localparam logic [1:0] REG_CAPACITY = 2'd0;

    localparam logic [4:0] CAP_RESET = 5'd16;
    localparam logic [4:0] CAP_MIN   = 5'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] data;
        logic [3:0]        occupancy;
    } t_res_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_REV_RD,
        S_REV_WA,
        S_REV_WB
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       enq;
        logic       deq;
        logic       rev_init;
        logic       rd;
        logic       wr_a;
        logic       wr_b;
        logic       emit;
        logic [1:0] status;
        logic       use_rd;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic few;
        logic last;
    } t_dp_stat;

endpackage

FILE: hw/rtl/cqr_regs.sv
// ----------------------------------------------------------------------------
// cqr_regs
// apb register file: capacity register and its clamped working value
// ----------------------------------------------------------------------------
module cqr_regs #(
    parameter int DEPTH = 16,
    parameter int PW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output logic          o_cap_wr,
    output logic [PW-1:0] o_cap
);
    import cqr_pkg::*;

    localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

    logic [4:0]    r_cap;
    logic [PW-1:0] cap_ext;
    logic          wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (wr_hit) begin
            r_cap <= pwdata[4:0];
        end
    end

    assign o_cap_wr = wr_hit;
    assign prdata   = (paddr == REG_CAPACITY) ? {27'd0, r_cap} : 32'd0;
    assign cap_ext  = PW'(r_cap);

    always_comb begin
        if (r_cap < CAP_MIN) begin
            o_cap = PW'(CAP_MIN);
        end else if (cap_ext > DEPTH_W) begin
            o_cap = DEPTH_W;
        end else begin
            o_cap = cap_ext;
        end
    end

endmodule

FILE: hw/rtl/cqr_ctrl.sv
// ----------------------------------------------------------------------------
// cqr_ctrl
// command sequencer: decodes items, steps the dequeue read and the reverse swap loop
// ----------------------------------------------------------------------------
module cqr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_command,
    input  cqr_pkg::t_dp_stat i_stat,
    output cqr_pkg::t_dp_ctl  o_ctl,
    output logic              busy
);
    import cqr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_command)
                        CMD_ENQ: begin
                            o_ctl.emit = 1'b1;
                            if (i_stat.full) begin
                                o_ctl.status = STAT_FULL;
                            end else begin
                                o_ctl.enq    = 1'b1;
                                o_ctl.status = STAT_OK;
                            end
                        end
                        CMD_DEQ: begin
                            if (i_stat.empty) begin
                                o_ctl.emit   = 1'b1;
                                o_ctl.status = STAT_EMPTY;
                            end else begin
                                o_ctl.deq = 1'b1;
                                o_ctl.rd  = 1'b1;
                                n_state   = S_DEQ;
                            end
                        end
                        CMD_REV: begin
                            // fewer than two entries: nothing to swap
                            if (i_stat.few) begin
                                o_ctl.emit   = 1'b1;
                                o_ctl.status = STAT_OK;
                            end else begin
                                o_ctl.rev_init = 1'b1;
                                n_state        = S_REV_RD;
                            end
                        end
                        default: begin
                            o_ctl.emit   = 1'b1;
                            o_ctl.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                o_ctl.emit   = 1'b1;
                o_ctl.status = STAT_OK;
                o_ctl.use_rd = 1'b1;
                n_state      = S_IDLE;
            end
            S_REV_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_REV_WA;
            end
            S_REV_WA: begin
                o_ctl.wr_a = 1'b1;
                n_state    = S_REV_WB;
            end
            S_REV_WB: begin
                o_ctl.wr_b = 1'b1;
                if (i_stat.last) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = STAT_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_REV_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/cqr_dp.sv
// ----------------------------------------------------------------------------
// cqr_dp
// datapath: slot memory, ring pointers, swap pointers and result register
// ----------------------------------------------------------------------------
module cqr_dp #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int PW    = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  logic [PW-1:0]      i_cap,
    input  logic signed [31:0] i_value,
    input  cqr_pkg::t_dp_ctl   i_ctl,
    output cqr_pkg::t_dp_stat  o_stat,
    output logic               o_valid,
    output cqr_pkg::t_res_item o_res
);
    import cqr_pkg::*;

    logic signed [31:0] mem [DEPTH];

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] r_pa, n_pa;
    logic [PW-1:0] r_pb, n_pb;
    logic [PW-1:0] r_cnt, n_cnt;
    logic signed [31:0] r_rd_a, r_rd_b;

    logic               r_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_data;
    logic [3:0]         r_occ;

    logic [PW-1:0]      head_inc, tail_inc, occ_now, occ_next;
    logic [PW-1:0]      rd_addr, wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] x, input logic [PW-1:0] c);
        logic [PW-1:0] y;
        y = x + PW'(1);
        return (y == c) ? '0 : y;
    endfunction

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] x, input logic [PW-1:0] c);
        return (x == '0) ? (c - PW'(1)) : (x - PW'(1));
    endfunction

    function automatic logic [PW-1:0] f_occ(input logic [PW-1:0] h, input logic [PW-1:0] t,
                                            input logic [PW-1:0] c);
        return (t >= h) ? (t - h) : (t + c - h);
    endfunction

    assign head_inc = f_inc(r_head, i_cap);
    assign tail_inc = f_inc(r_tail, i_cap);
    assign occ_now  = f_occ(r_head, r_tail, i_cap);

    assign o_stat.full  = (tail_inc == r_head);
    assign o_stat.empty = (r_head == r_tail);
    assign o_stat.few   = (occ_now < PW'(2));
    assign o_stat.last  = (r_cnt == PW'(1));

    // ring and swap pointers
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_pa   = r_pa;
        n_pb   = r_pb;
        n_cnt  = r_cnt;
        if (i_clr) begin
            n_head = '0;
            n_tail = '0;
        end else if (i_ctl.enq) begin
            n_tail = tail_inc;
        end else if (i_ctl.deq) begin
            // last entry leaves: both pointers return to slot zero
            if (head_inc == r_tail) begin
                n_head = '0;
                n_tail = '0;
            end else begin
                n_head = head_inc;
            end
        end else if (i_ctl.rev_init) begin
            n_pa  = head_inc;
            n_pb  = r_tail;
            n_cnt = occ_now >> 1;
        end else if (i_ctl.wr_b) begin
            n_pa  = f_inc(r_pa, i_cap);
            n_pb  = f_dec(r_pb, i_cap);
            n_cnt = r_cnt - PW'(1);
        end
    end

    assign occ_next = f_occ(n_head, n_tail, i_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= n_pa;
        r_pb <= n_pb;
        if (i_ctl.emit) begin
            r_status <= i_ctl.status;
            r_data   <= i_ctl.use_rd ? r_rd_a : 32'sd0;
            r_occ    <= occ_next[3:0];
        end
    end

    // one write port, two registered read ports
    assign wr_en   = i_ctl.enq || i_ctl.wr_a || i_ctl.wr_b;
    assign wr_addr = i_ctl.enq ? tail_inc : (i_ctl.wr_a ? r_pa : r_pb);
    assign wr_data = i_ctl.enq ? i_value : (i_ctl.wr_a ? r_rd_b : r_rd_a);
    assign rd_addr = i_ctl.deq ? head_inc : r_pa;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_a <= mem[rd_addr[AW-1:0]];
            r_rd_b <= mem[r_pb[AW-1:0]];
        end
    end

    assign o_valid         = r_valid;
    assign o_res.status    = r_status;
    assign o_res.data      = r_data;
    assign o_res.occupancy = r_occ;

endmodule

FILE: hw/rtl/circular_queue_with_reverse_core.sv
// ----------------------------------------------------------------------------
// circular_queue_with_reverse_core
// ring-buffer fifo of signed words with in-place reversal
// ----------------------------------------------------------------------------
// An item is a command (enqueue, dequeue, reverse) with a value, taken at a
// clock edge where start is high and busy is low. Every item gives one result
// (status, data, occupancy) on o_res, marked by o_valid for one cycle; the
// receiver cannot stall, so results are simply taken as they appear.
// From the accepting edge to the result:
//   enqueue, full enqueue, empty dequeue, short reverse, unused code: result in
//     the next cycle, and busy stays low, so one such item is taken every cycle
//   dequeue of a stored entry: registered memory read, then result register
//   reverse of n entries: floor(n/2) pairs, each a read on both memory read
//     ports then one write per slot; the result register follows the last pair
// busy is high while a dequeue read or a reverse swap loop is in progress.
// A ring of capacity slots holds capacity-1 entries; capacity is the APB
// register at byte address 0, clamped to 2..DEPTH, and writing it empties
// the queue. Reset empties the queue and sets capacity to 16; slot contents
// are not cleared, and only written slots are read for results or swaps.
module circular_queue_with_reverse_core #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cqr_pkg::t_cmd_item i_cmd,
    output logic               o_valid,
    output cqr_pkg::t_res_item o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cqr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = ((AW > 5) ? AW : 5) + 1;

    logic          cap_wr;
    logic [PW-1:0] cap;
    t_dp_ctl       ctl;
    t_dp_stat      stat;

    cqr_regs #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cap_wr (cap_wr),
        .o_cap    (cap)
    );

    cqr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_cmd.command),
        .i_stat    (stat),
        .o_ctl     (ctl),
        .busy      (busy)
    );

    cqr_dp #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .PW    (PW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (cap_wr),
        .i_cap   (cap),
        .i_value (i_cmd.value),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

FILE: hw/rtl/cqr_checker.sv
// ----------------------------------------------------------------------------
// cqr_checker
// port-level assertions for the circular queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cqr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input cqr_pkg::t_cmd_item i_cmd,
    input logic               o_valid,
    input cqr_pkg::t_res_item o_res
);
    import cqr_pkg::*;

    // enqueue never waits on the memory
    `CQR_ASSERT_NEXT(a_enq_result, i_clk, i_rst_n,
        start && !busy && (i_cmd.command == CMD_ENQ), o_valid, "enqueue result missing")

    // a dequeue either answers at once or holds busy for its read
    `CQR_ASSERT_NEXT(a_deq_progress, i_clk, i_rst_n,
        start && !busy && (i_cmd.command == CMD_DEQ), busy || o_valid, "dequeue stalled")

    `CQR_ASSERT_NOW(a_fail_data, i_clk, i_rst_n,
        o_valid && (o_res.status != STAT_OK), o_res.data == 32'sd0, "data on failed item")

    `CQR_ASSERT_NOW(a_empty_occ, i_clk, i_rst_n,
        o_valid && (o_res.status == STAT_EMPTY), o_res.occupancy == 4'd0,
        "empty status with entries")

endmodule

bind circular_queue_with_reverse_core cqr_checker u_cqr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid),
    .o_res   (o_res)
);
